### sv/pkha_pkg.sv
`timescale 1ns / 1ps
package pkha_pkg;

  localparam int SUM_W = 40;
  localparam int VALUE_W = 32;
  localparam int SLOT_OUT_W = 12;

  localparam logic CMD_ACCUMULATE = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  localparam logic [2:0] MODE_ADD = 3'd1;
  localparam logic [2:0] MODE_QUARTER = 3'd2;
  localparam logic [2:0] MODE_SPLIT = 3'd3;
  localparam logic [2:0] MODE_MOVE = 3'd4;
  localparam logic [2:0] MODE_ASSIGN = 3'd5;

  localparam logic [9:0] NARROW_MASK = 10'd127;
  localparam logic [9:0] WIDE_MASK = 10'd1023;

  typedef struct packed {
    logic                      command;
    logic [7:0]                index_i;
    logic [7:0]                index_j;
    logic [7:0]                index_k;
    logic [7:0]                index_l;
    logic signed [VALUE_W-1:0] sample_value;
    logic [2:0]                update_mode;
  } in_beat_t;

  typedef struct packed {
    logic [SLOT_OUT_W-1:0]   entry_index;
    logic                    created_entry;
    logic                    table_full;
    logic signed [SUM_W-1:0] sum_first;
    logic signed [SUM_W-1:0] sum_second;
  } out_beat_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_KEY,
    S_HEAD,
    S_HWAIT,
    S_WALK,
    S_CMP,
    S_LINK,
    S_UPD,
    S_DONE
  } state_t;

endpackage

### sv/pair_key_hash_accumulator.sv
`timescale 1ns / 1ps
// Chained hash table that accumulates two saturating Q16.24 sums per pair of
// orbital pairs. Each beat hashes its two triangular pair keys into a bucket and
// walks that bucket's chain one entry at a time through the entry memory.
// An accumulate beat holds the input while it forms the keys, reads the bucket
// head, walks the chain and writes the entry, with a link step added when a new
// entry is appended; every compared entry costs one registered read and one
// compare. A clear beat, and the sweep that follows reset, both clear the bucket
// head memory one bucket per cycle while no beat is taken. The output register
// lets the next beat start while a result waits to be taken; a beat that
// finishes while the previous result still waits holds in its last cycle until
// that result leaves.
module pair_key_hash_accumulator #(
  parameter int TABLE_ENTRIES = 4096,
  parameter int MAX_BUCKETS = 1024,
  parameter int ORBITAL_BITS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  pkha_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output pkha_pkg::out_beat_t out_data
);

  localparam int KEY_W = 2 * ORBITAL_BITS;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int HB = $clog2(MAX_BUCKETS);
  localparam int HW = (KEY_W + 2 > HB) ? KEY_W + 2 : HB;
  localparam int SW = pkha_pkg::SUM_W;
  localparam int EW = CNT_W + 2 * KEY_W + 2 * SW;
  localparam int TW = pkha_pkg::VALUE_W + 5;
  localparam int AW = SW + 2;
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_ENTRIES);
  localparam logic [HB-1:0] LAST_BUCKET = HB'(MAX_BUCKETS - 1);
  localparam logic signed [AW-1:0] SUM_MAX = AW'({1'b0, {(SW-1){1'b1}}});
  localparam logic signed [AW-1:0] SUM_MIN = -SUM_MAX - AW'(1);

  pkha_pkg::state_t state, state_next;
  pkha_pkg::in_beat_t item;
  logic wide_hash;
  logic [KEY_W-1:0] ka, kb;
  logic [HB-1:0] bucket, clr_addr;
  logic [CNT_W-1:0] node, prev, steps, count, link_keep;
  logic [EW-1:0] prev_word;
  logic [IDX_W-1:0] slot;
  logic signed [SW-1:0] acc_a, acc_b;
  logic signed [TW-1:0] d1, d2;
  logic created, full, clr_pend;

  logic head_we;
  logic [HB-1:0] head_waddr, head_raddr;
  logic [CNT_W-1:0] head_wdata, head_rdata;
  logic ent_we;
  logic [IDX_W-1:0] ent_waddr, ent_raddr;
  logic [EW-1:0] ent_wdata, ent_rdata;

  logic [CNT_W-1:0] r_link;
  logic [KEY_W-1:0] r_ka, r_kb;
  logic signed [SW-1:0] r_a, r_b;
  assign {r_link, r_ka, r_kb, r_a, r_b} = ent_rdata;

  pkha_ram #(.WIDTH(CNT_W), .DEPTH(MAX_BUCKETS)) u_heads (
    .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
    .raddr(head_raddr), .rdata(head_rdata)
  );

  pkha_ram #(.WIDTH(EW), .DEPTH(TABLE_ENTRIES)) u_entries (
    .clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(ent_wdata),
    .raddr(ent_raddr), .rdata(ent_rdata)
  );

  function automatic logic [KEY_W-1:0] pair_key(input logic [7:0] a, input logic [7:0] b);
    logic [ORBITAL_BITS-1:0] x, y;
    logic [KEY_W:0] p;
    x = ORBITAL_BITS'(a);
    y = ORBITAL_BITS'(b);
    p = (KEY_W+1)'(x) * (KEY_W+1)'({1'b0, x} + (ORBITAL_BITS+1)'(1));
    return KEY_W'(p >> 1) + KEY_W'(y);
  endfunction

  function automatic logic signed [TW-1:0] scaled(input logic signed [31:0] v,
                                                  input logic [3:0] m);
    logic signed [TW-1:0] t;
    t = TW'(v) * TW'($signed({1'b0, m})) + TW'(4);
    return t >>> 3;
  endfunction

  function automatic logic signed [SW-1:0] sat(input logic signed [AW-1:0] x);
    if (x > SUM_MAX) return SW'(SUM_MAX);
    if (x < SUM_MIN) return SW'(SUM_MIN);
    return SW'(x);
  endfunction

  logic [HW-1:0] hsum;
  logic [9:0] hmask;
  logic [3:0] h, m1, m2;
  logic signed [SW-1:0] new_a, new_b;
  logic signed [AW-1:0] a_x, b_x, d1_x, d2_x;
  logic walk_ok;

  always_comb begin
    hmask = wide_hash ? pkha_pkg::WIDE_MASK : pkha_pkg::NARROW_MASK;
    hsum = (HW'(ka) << 1) + HW'(kb);
    hsum = hsum & HW'(hmask);
    h = (ka == kb) ? 4'd1 : 4'd2;
    m1 = 4'd0;
    m2 = 4'd0;
    case (item.update_mode)
      pkha_pkg::MODE_ADD:     m1 = h << 2;
      pkha_pkg::MODE_QUARTER: m1 = h;
      pkha_pkg::MODE_SPLIT: begin
        m1 = (h << 1) + h;
        m2 = h;
      end
      pkha_pkg::MODE_MOVE:    m1 = h << 1;
      pkha_pkg::MODE_ASSIGN:  m1 = h << 1;
      default:                m1 = 4'd0;
    endcase
    a_x = AW'(acc_a);
    b_x = AW'(acc_b);
    d1_x = AW'(d1);
    d2_x = AW'(d2);
    new_a = acc_a;
    new_b = acc_b;
    case (item.update_mode)
      pkha_pkg::MODE_ADD:     new_a = sat(a_x + d1_x);
      pkha_pkg::MODE_QUARTER: begin
        new_a = sat(a_x - d1_x);
        new_b = sat(b_x + d1_x);
      end
      pkha_pkg::MODE_SPLIT: begin
        new_a = sat(a_x + d1_x);
        new_b = sat(b_x + d2_x);
      end
      pkha_pkg::MODE_MOVE: begin
        new_a = sat(a_x - d1_x);
        new_b = sat(d1_x);
      end
      pkha_pkg::MODE_ASSIGN: begin
        new_a = sat(d1_x);
        new_b = sat(d1_x);
      end
      default: begin
        new_a = acc_a;
        new_b = acc_b;
      end
    endcase
    walk_ok = (node != '0) && (node <= count) && (steps <= count);
  end

  always_comb begin
    state_next = state;
    in_stall = (state != pkha_pkg::S_IDLE);
    head_we = 1'b0;
    head_waddr = bucket;
    head_wdata = count + CNT_W'(1);
    head_raddr = hsum[HB-1:0];
    ent_we = 1'b0;
    ent_waddr = slot;
    ent_wdata = {link_keep, ka, kb, new_a, new_b};
    ent_raddr = IDX_W'(node - CNT_W'(1));
    case (state)
      pkha_pkg::S_CLEAR: begin
        head_we = 1'b1;
        head_waddr = clr_addr;
        head_wdata = '0;
        if (clr_addr == LAST_BUCKET) begin
          state_next = clr_pend ? pkha_pkg::S_DONE : pkha_pkg::S_IDLE;
        end
      end
      pkha_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = (in_data.command == pkha_pkg::CMD_CLEAR) ?
                       pkha_pkg::S_CLEAR : pkha_pkg::S_KEY;
        end
      end
      pkha_pkg::S_KEY:   state_next = pkha_pkg::S_HEAD;
      pkha_pkg::S_HEAD:  state_next = pkha_pkg::S_HWAIT;
      pkha_pkg::S_HWAIT: state_next = pkha_pkg::S_WALK;
      pkha_pkg::S_WALK: begin
        if (walk_ok) begin
          state_next = pkha_pkg::S_CMP;
        end else if (count >= FULL_COUNT) begin
          state_next = pkha_pkg::S_DONE;
        end else begin
          state_next = pkha_pkg::S_LINK;
        end
      end
      pkha_pkg::S_CMP: begin
        state_next = (r_ka == ka && r_kb == kb) ? pkha_pkg::S_UPD : pkha_pkg::S_WALK;
      end
      pkha_pkg::S_LINK: begin
        if (prev == '0) begin
          head_we = 1'b1;
        end else begin
          ent_we = 1'b1;
          ent_waddr = IDX_W'(prev - CNT_W'(1));
          ent_wdata = {count + CNT_W'(1), prev_word[EW-CNT_W-1:0]};
        end
        state_next = pkha_pkg::S_UPD;
      end
      pkha_pkg::S_UPD: begin
        ent_we = 1'b1;
        state_next = pkha_pkg::S_DONE;
      end
      pkha_pkg::S_DONE: begin
        if (!out_valid) begin
          state_next = pkha_pkg::S_IDLE;
        end
      end
      default: state_next = pkha_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pkha_pkg::S_CLEAR;
      wide_hash <= 1'b1;
      count <= '0;
      clr_addr <= '0;
      clr_pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        wide_hash <= cfg_data;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        pkha_pkg::S_CLEAR: clr_addr <= clr_addr + HB'(1);
        pkha_pkg::S_IDLE: begin
          if (in_valid && in_data.command == pkha_pkg::CMD_CLEAR) begin
            count <= '0;
            clr_addr <= '0;
            clr_pend <= 1'b1;
          end
        end
        pkha_pkg::S_LINK: count <= count + CNT_W'(1);
        pkha_pkg::S_DONE: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            clr_pend <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      pkha_pkg::S_IDLE: begin
        item <= in_data;
        slot <= '0;
        acc_a <= '0;
        acc_b <= '0;
        created <= 1'b0;
        full <= 1'b0;
      end
      pkha_pkg::S_KEY: begin
        ka <= pair_key(item.index_i, item.index_j);
        kb <= pair_key(item.index_k, item.index_l);
      end
      pkha_pkg::S_HEAD: begin
        bucket <= hsum[HB-1:0];
        d1 <= scaled(item.sample_value, m1);
        d2 <= scaled(item.sample_value, m2);
        prev <= '0;
        steps <= '0;
      end
      pkha_pkg::S_HWAIT: node <= head_rdata;
      pkha_pkg::S_WALK: begin
        if (!walk_ok) begin
          if (count >= FULL_COUNT) begin
            full <= 1'b1;
          end else begin
            slot <= IDX_W'(count);
            created <= 1'b1;
            link_keep <= '0;
          end
        end
      end
      pkha_pkg::S_CMP: begin
        if (r_ka == ka && r_kb == kb) begin
          slot <= IDX_W'(node - CNT_W'(1));
          acc_a <= r_a;
          acc_b <= r_b;
          link_keep <= r_link;
        end else begin
          prev <= node;
          prev_word <= ent_rdata;
          node <= r_link;
          steps <= steps + CNT_W'(1);
        end
      end
      pkha_pkg::S_UPD: begin
        acc_a <= new_a;
        acc_b <= new_b;
      end
      pkha_pkg::S_DONE: begin
        if (!out_valid) begin
          out_data.entry_index <= pkha_pkg::SLOT_OUT_W'(slot);
          out_data.created_entry <= created;
          out_data.table_full <= full;
          out_data.sum_first <= acc_a;
          out_data.sum_second <= acc_b;
        end
      end
      default: ;
    endcase
  end

endmodule

### sv/pkha_ram.sv
`timescale 1ns / 1ps
module pkha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_data = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  pkha_pkg::in_beat_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  pkha_pkg::out_beat_t out_data;

  pair_key_hash_accumulator DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #6 clk = ~clk;

  pkha_pkg::in_beat_t pending_beats[$];
  pkha_pkg::out_beat_t expected_entries[$];
  int errors = 0;
  int beats_sent = 0;
  int results_seen = 0;
  int hold_requests = 0;
  int holds_served = 0;

  bit wide_sel;
  int head_of[1024];
  int link_of[4097];
  int key_a_of[4096];
  int key_b_of[4096];
  longint acc_a[4096];
  longint acc_b[4096];
  int entries_used;

  localparam longint SUM_HI = 64'sd549755813887;
  localparam longint SUM_LO = -64'sd549755813888;

  task automatic empty_table();
    foreach (head_of[n]) head_of[n] = 0;
    foreach (link_of[n]) link_of[n] = 0;
    entries_used = 0;
  endtask

  function automatic longint clamp40(longint x);
    if (x > SUM_HI) return SUM_HI;
    if (x < SUM_LO) return SUM_LO;
    return x;
  endfunction

  function automatic longint eighths(longint v, longint m);
    longint t;
    t = v * m + 4;
    return t >>> 3;
  endfunction

  task automatic accumulate_pair(input pkha_pkg::in_beat_t b, output pkha_pkg::out_beat_t r);
    int ka, kb, bucket, node, prev, steps, slot;
    bit found;
    longint v, half, d1, d2;
    r = '0;
    found = 0;
    if (b.command == pkha_pkg::CMD_CLEAR) begin
      empty_table();
    end else begin
      ka = int'(b.index_i) * (int'(b.index_i) + 1) / 2 + int'(b.index_j);
      kb = int'(b.index_k) * (int'(b.index_k) + 1) / 2 + int'(b.index_l);
      bucket = (2 * ka + kb) & (wide_sel ? 1023 : 127);
      v = longint'(b.sample_value);
      prev = 0;
      slot = 0;
      steps = 0;
      node = head_of[bucket];
      while (!found && node != 0 && node <= entries_used && steps <= entries_used) begin
        if (key_a_of[node-1] == ka && key_b_of[node-1] == kb) begin
          slot = node - 1;
          found = 1;
        end else begin
          prev = node;
          node = link_of[node];
          steps++;
        end
      end
      if (!found && entries_used >= 4096) begin
        r.table_full = 1'b1;
      end else begin
        if (!found) begin
          slot = entries_used;
          entries_used++;
          if (prev == 0) head_of[bucket] = entries_used;
          else link_of[prev] = entries_used;
          link_of[entries_used] = 0;
          key_a_of[slot] = ka;
          key_b_of[slot] = kb;
          acc_a[slot] = 0;
          acc_b[slot] = 0;
          r.created_entry = 1'b1;
        end
        half = (ka == kb) ? 1 : 2;
        case (b.update_mode)
          pkha_pkg::MODE_ADD: begin
            d1 = eighths(v, 4 * half);
            acc_a[slot] = clamp40(acc_a[slot] + d1);
          end
          pkha_pkg::MODE_QUARTER: begin
            d1 = eighths(v, half);
            acc_a[slot] = clamp40(acc_a[slot] - d1);
            acc_b[slot] = clamp40(acc_b[slot] + d1);
          end
          pkha_pkg::MODE_SPLIT: begin
            d1 = eighths(v, 3 * half);
            d2 = eighths(v, half);
            acc_a[slot] = clamp40(acc_a[slot] + d1);
            acc_b[slot] = clamp40(acc_b[slot] + d2);
          end
          pkha_pkg::MODE_MOVE: begin
            d1 = eighths(v, 2 * half);
            acc_a[slot] = clamp40(acc_a[slot] - d1);
            acc_b[slot] = clamp40(d1);
          end
          pkha_pkg::MODE_ASSIGN: begin
            d1 = eighths(v, 2 * half);
            acc_a[slot] = clamp40(d1);
            acc_b[slot] = clamp40(d1);
          end
          default: ;
        endcase
        r.entry_index = slot[11:0];
        r.sum_first = acc_a[slot][39:0];
        r.sum_second = acc_b[slot][39:0];
      end
    end
  endtask

  function automatic int gap_length();
    int p;
    p = $urandom_range(99);
    if (p < 65) return 0;
    if (p < 95) return $urandom_range(3, 1);
    return $urandom_range(60, 15);
  endfunction

  int send_gap = 0;
  bit drive_gaps = 1'b1;

  always @(posedge clk) begin
    pkha_pkg::out_beat_t r;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        accumulate_pair(in_data, r);
        expected_entries.push_back(r);
        beats_sent++;
      end
      if (in_valid && in_stall) begin
        in_valid <= 1'b1;
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_beats.size() > 0) begin
        in_data <= pending_beats.pop_front();
        in_valid <= 1'b1;
        send_gap <= drive_gaps ? gap_length() : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  int hold_left = 0;
  int stall_left = 0;

  always @(posedge clk) begin
    pkha_pkg::out_beat_t e;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (expected_entries.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        e = expected_entries.pop_front();
        if (out_data.entry_index !== e.entry_index) begin
          $error("entry_index expected %0d actual %0d", e.entry_index, out_data.entry_index);
          errors++;
        end
        if (out_data.created_entry !== e.created_entry) begin
          $error("created_entry expected %0d actual %0d", e.created_entry,
                 out_data.created_entry);
          errors++;
        end
        if (out_data.table_full !== e.table_full) begin
          $error("table_full expected %0d actual %0d", e.table_full, out_data.table_full);
          errors++;
        end
        if (out_data.sum_first !== e.sum_first) begin
          $error("sum_first expected %0d actual %0d", e.sum_first, out_data.sum_first);
          errors++;
        end
        if (out_data.sum_second !== e.sum_second) begin
          $error("sum_second expected %0d actual %0d", e.sum_second, out_data.sum_second);
          errors++;
        end
      end
    end
    if (hold_requests != holds_served) begin
      holds_served <= holds_served + 1;
      hold_left <= 400;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (drive_gaps) begin
      stall_left <= gap_length();
      out_stall <= 1'b0;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic pkha_pkg::in_beat_t make_beat(logic cmd, int i, int j, int k, int l,
                                                   longint v, int mode);
    pkha_pkg::in_beat_t b;
    b.command = cmd;
    b.index_i = i[7:0];
    b.index_j = j[7:0];
    b.index_k = k[7:0];
    b.index_l = l[7:0];
    b.sample_value = v[31:0];
    b.update_mode = mode[2:0];
    return b;
  endfunction

  function automatic pkha_pkg::in_beat_t random_beat();
    int p, top;
    longint v;
    logic cmd;
    p = $urandom_range(99);
    top = ($urandom_range(9) == 0) ? 255 : 5;
    if (p < 10) v = 64'sh7fffffff;
    else if (p < 20) v = -64'sh80000000;
    else v = longint'($signed($urandom()));
    cmd = ($urandom_range(49) == 0) ? pkha_pkg::CMD_CLEAR : pkha_pkg::CMD_ACCUMULATE;
    return make_beat(cmd, $urandom_range(top), $urandom_range(top),
                     $urandom_range(top), $urandom_range(top), v, $urandom_range(7));
  endfunction

  task automatic drain_all();
    do @(negedge clk);
    while (pending_beats.size() > 0 || in_valid || expected_entries.size() > 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_wide(bit val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    wide_sel = val;
  endtask

  task automatic run_random(int count);
    for (int n = 0; n < count; n++) begin
      pending_beats.push_back(random_beat());
      if (pending_beats.size() > 20)
        while (pending_beats.size() > 4) @(posedge clk);
    end
  endtask

  initial begin
    wide_sel = 1'b1;
    empty_table();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    pending_beats.push_back(make_beat(pkha_pkg::CMD_ACCUMULATE, 255, 255, 255, 255,
                                      64'sh7fffffff, pkha_pkg::MODE_ADD));
    pending_beats.push_back(make_beat(pkha_pkg::CMD_ACCUMULATE, 0, 0, 0, 0,
                                      -64'sh80000000, pkha_pkg::MODE_ADD));
    pending_beats.push_back(make_beat(pkha_pkg::CMD_ACCUMULATE, 3, 1, 3, 1, 1000,
                                      pkha_pkg::MODE_QUARTER));
    pending_beats.push_back(make_beat(pkha_pkg::CMD_ACCUMULATE, 3, 1, 3, 1, -7,
                                      pkha_pkg::MODE_SPLIT));
    pending_beats.push_back(make_beat(pkha_pkg::CMD_ACCUMULATE, 3, 1, 3, 1, 5,
                                      pkha_pkg::MODE_MOVE));
    pending_beats.push_back(make_beat(pkha_pkg::CMD_ACCUMULATE, 3, 1, 3, 1, -3,
                                      pkha_pkg::MODE_ASSIGN));
    for (int m = 0; m < 8; m++)
      pending_beats.push_back(make_beat(pkha_pkg::CMD_ACCUMULATE, 7, 2, 4, 4,
                                        64'sh01234567, m));
    pending_beats.push_back(make_beat(pkha_pkg::CMD_ACCUMULATE, 1, 9, 0, 200, -12345,
                                      pkha_pkg::MODE_ADD));
    pending_beats.push_back(make_beat(pkha_pkg::CMD_ACCUMULATE, 255, 0, 0, 255, 1,
                                      pkha_pkg::MODE_SPLIT));
    pending_beats.push_back(make_beat(pkha_pkg::CMD_ACCUMULATE, 255, 255, 255, 255,
                                      64'sh7fffffff, pkha_pkg::MODE_ADD));
    pending_beats.push_back(make_beat(pkha_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0));
    pending_beats.push_back(make_beat(pkha_pkg::CMD_ACCUMULATE, 255, 255, 255, 255, 9,
                                      pkha_pkg::MODE_ADD));
    drain_all();

    write_wide(1'b0);
    pending_beats.push_back(make_beat(pkha_pkg::CMD_ACCUMULATE, 255, 255, 255, 255, 9,
                                      pkha_pkg::MODE_ADD));
    pending_beats.push_back(make_beat(pkha_pkg::CMD_ACCUMULATE, 10, 3, 20, 6, 77,
                                      pkha_pkg::MODE_ADD));
    run_random(350);
    hold_requests = 1;
    run_random(20);
    drain_all();

    write_wide(1'b1);
    for (int n = 0; n < 260; n++)
      pending_beats.push_back(make_beat(pkha_pkg::CMD_ACCUMULATE, 6, 1, 2, 0,
                                        64'sh7fffffff, pkha_pkg::MODE_ADD));
    for (int n = 0; n < 40; n++)
      pending_beats.push_back(make_beat(pkha_pkg::CMD_ACCUMULATE, 6, 1, 2, 0,
                                        -64'sh80000000, pkha_pkg::MODE_SPLIT));
    run_random(200);
    drain_all();

    write_wide(1'b0);
    run_random(250);
    drain_all();

    drive_gaps = 1'b0;
    pending_beats.push_back(make_beat(pkha_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0));
    for (int n = 0; n < 100; n++)
      pending_beats.push_back(make_beat(pkha_pkg::CMD_ACCUMULATE, 255, n % 16, n / 16, 0,
                                        n, pkha_pkg::MODE_ADD));
    pending_beats.push_back(make_beat(pkha_pkg::CMD_ACCUMULATE, 255, 5, 0, 0, 1,
                                      pkha_pkg::MODE_ADD));
    pending_beats.push_back(make_beat(pkha_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0));
    pending_beats.push_back(make_beat(pkha_pkg::CMD_ACCUMULATE, 255, 5, 0, 0, 1,
                                      pkha_pkg::MODE_ADD));
    drain_all();
    drive_gaps = 1'b1;

    $display("Covered %0d beats and %0d results over both hash widths, clears,",
             beats_sent, results_seen);
    $display("saturation, long chains, back to back beats and a long receiver hold.");
    if (errors == 0) begin
      $display("pair_key_hash_accumulator regression: pass");
    end else begin
      $display("pair_key_hash_accumulator regression: fail");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("pair_key_hash_accumulator regression: fail");
    $finish;
  end

endmodule
